/* design/signed_angle_about_normal_defines.svh */
// assertion macros for the signed angle block
`ifndef SIGNED_ANGLE_ABOUT_NORMAL_DEFINES_SVH
`define SIGNED_ANGLE_ABOUT_NORMAL_DEFINES_SVH
`ifndef ASSERT_OFF
`define SAN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SAN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SAN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/san_pkg.sv */
package san_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int CORDIC_STEPS = 31;
    // edge components
    localparam int EW = COORD_WIDTH + 1;
    // cross and dot products
    localparam int PW = 2 * EW + 2;
    // y dot and norm square
    localparam int YW = PW + COORD_WIDTH + 2;
    localparam int NNW = 2 * COORD_WIDTH + 2;
    // norm in q8, floor(sqrt(nn * 2^16))
    localparam int MW = NNW / 2 + 8 + 1;
    // atan2 arguments, magnitudes
    localparam int AW = 128;
    // sqrt iterations
    localparam int SQ_STEPS = MW;
    localparam int PIPE_DEPTH = 5 + SQ_STEPS + 1 + 1 + CORDIC_STEPS + 1;

    typedef logic [CORDIC_STEPS-1:0][31:0] atan_tab_t;
    localparam atan_tab_t ATAN_TAB = {
        32'h00000001, 32'h00000001, 32'h00000003, 32'h00000005, 32'h0000000A,
        32'h00000014, 32'h00000029, 32'h00000051, 32'h000000A3, 32'h00000146,
        32'h0000028C, 32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
        32'h0000517D, 32'h0000A2F9, 32'h000145F3, 32'h00028BE6, 32'h000517CC,
        32'h000A2F98, 32'h00145F2F, 32'h0028BE53, 32'h00517C55, 32'h00A2F61E,
        32'h0145D7E1, 32'h028B0D43, 32'h051111D4, 32'h09FB385B, 32'h12E4051E,
        32'h20000000
    };
endpackage

/* design/signed_angle_about_normal.sv */
// signed angle about a normal, pipelined
// input channel: in_valid/in_ready carries one beat of vertex, first, second
// and axis points (signed coordinates); output channel: out_valid/out_ready
// carries angle (2^15 = pi) and axis_zero
// one beat per cycle sustained while the receiver does not stall; 65 register
// stages from the input register to out_valid: 5 product stages, 26 norm
// square root stages (one bit each), 1 multiply, 1 normalize, 31 cordic
// stages, 1 rounding stage
// reset clears all valid bits; the pipeline is empty afterwards
// when the receiver stalls the whole pipeline holds; in_ready follows
// out_ready or an empty output stage, so nothing is lost or repeated
// zero axis gives angle 0 and axis_zero 1
// zero atan2 arguments give angle 0
`include "signed_angle_about_normal_defines.svh"
module signed_angle_about_normal
    import san_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_z,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_z,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_z,
    input  logic signed [COORD_WIDTH-1:0] axis_x,
    input  logic signed [COORD_WIDTH-1:0] axis_y,
    input  logic signed [COORD_WIDTH-1:0] axis_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ANGLE_WIDTH-1:0] angle,
    output logic                          axis_zero
);
    // global stall: whole pipeline advances together
    logic adv;
    assign adv = !out_valid || out_ready;
    assign in_ready = adv;

    // stage 1: edges
    logic                 v1_reg;
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [COORD_WIDTH-1:0] n1_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg[0] <= EW'(first_x) - EW'(vertex_x);
            e1_reg[1] <= EW'(first_y) - EW'(vertex_y);
            e1_reg[2] <= EW'(first_z) - EW'(vertex_z);
            e2_reg[0] <= EW'(second_x) - EW'(vertex_x);
            e2_reg[1] <= EW'(second_y) - EW'(vertex_y);
            e2_reg[2] <= EW'(second_z) - EW'(vertex_z);
            n1_reg[0] <= axis_x;
            n1_reg[1] <= axis_y;
            n1_reg[2] <= axis_z;
        end
    end

    // stage 2: single products
    logic                 v2_reg;
    logic signed [PW-1:0] cpa_reg [3];
    logic signed [PW-1:0] cpb_reg [3];
    logic signed [PW-1:0] dp_reg  [3];
    logic [NNW-1:0]       nsq_reg [3];
    logic signed [COORD_WIDTH-1:0] n2_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cpa_reg[i] <= PW'(e1_reg[(i+1)%3] * e2_reg[(i+2)%3]);
                cpb_reg[i] <= PW'(e1_reg[(i+2)%3] * e2_reg[(i+1)%3]);
                dp_reg[i]  <= PW'(e1_reg[i] * e2_reg[i]);
                nsq_reg[i] <= NNW'(unsigned'(PW'(n1_reg[i] * n1_reg[i])));
                n2_reg[i]  <= n1_reg[i];
            end
        end
    end

    // stage 3: cross product, dot sum, norm square
    logic                 v3_reg;
    logic signed [PW-1:0] cp_reg [3];
    logic signed [PW-1:0] d3_reg;
    logic [NNW-1:0]       nn3_reg;
    logic signed [COORD_WIDTH-1:0] n3_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cp_reg[i] <= cpa_reg[i] - cpb_reg[i];
                n3_reg[i] <= n2_reg[i];
            end
            d3_reg  <= dp_reg[0] + dp_reg[1] + dp_reg[2];
            nn3_reg <= nsq_reg[0] + nsq_reg[1] + nsq_reg[2];
        end
    end

    // stage 4: cp.n products
    logic                 v4_reg;
    logic signed [YW-1:0] yp_reg [3];
    logic signed [PW-1:0] d4_reg;
    logic [NNW-1:0]       nn4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                yp_reg[i] <= YW'(cp_reg[i] * n3_reg[i]);
            d4_reg  <= d3_reg;
            nn4_reg <= nn3_reg;
        end
    end

    // stage 5: y dot sum; square root radicand set up
    logic                 v5_reg;
    logic signed [YW-1:0] y5_reg;
    logic signed [PW-1:0] d5_reg;
    logic [NNW+15:0]      rad5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y5_reg   <= yp_reg[0] + yp_reg[1] + yp_reg[2];
            d5_reg   <= d4_reg;
            rad5_reg <= {nn4_reg, 16'd0};
        end
    end

    // square root stages, one result bit per stage, msb first
    localparam int RW = NNW + 16;
    logic                 sqv_reg [SQ_STEPS+1];
    logic [MW-1:0]        sqr_reg [SQ_STEPS+1];
    logic [RW-1:0]        sqn_reg [SQ_STEPS+1];
    logic signed [YW-1:0] sqy_reg [SQ_STEPS+1];
    logic signed [PW-1:0] sqd_reg [SQ_STEPS+1];
    always_comb
    begin
        sqv_reg[0] = v5_reg;
        sqr_reg[0] = '0;
        sqn_reg[0] = rad5_reg;
        sqy_reg[0] = y5_reg;
        sqd_reg[0] = d5_reg;
    end
    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - s;
        logic [MW-1:0]   cand;
        logic [2*MW-1:0] csq;
        assign cand = sqr_reg[s] | (MW'(1) << B);
        assign csq  = cand * cand;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sqv_reg[s+1] <= 1'b0;
            else if (adv)
                sqv_reg[s+1] <= sqv_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqr_reg[s+1] <= ((2*MW+1)'(csq) <= (2*MW+1)'(sqn_reg[s]))
                                ? cand : sqr_reg[s];
                sqn_reg[s+1] <= sqn_reg[s];
                sqy_reg[s+1] <= sqy_reg[s];
                sqd_reg[s+1] <= sqd_reg[s];
            end
        end
    end

    // stage x: x = d * mag, y = ydot * 2^8, magnitudes and signs
    logic           vx_reg;
    logic [AW-1:0]  xm_reg;
    logic [AW-1:0]  ym_reg;
    logic           xn_reg;
    logic           yn_reg;
    logic           zn_reg;
    logic [PW-1:0]  dabs;
    logic [YW-1:0]  yabs;
    assign dabs = sqd_reg[SQ_STEPS][PW-1] ? PW'(-sqd_reg[SQ_STEPS]) : sqd_reg[SQ_STEPS];
    assign yabs = sqy_reg[SQ_STEPS][YW-1] ? YW'(-sqy_reg[SQ_STEPS]) : sqy_reg[SQ_STEPS];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vx_reg <= 1'b0;
        else if (adv)
            vx_reg <= sqv_reg[SQ_STEPS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xm_reg <= AW'(dabs) * AW'(sqr_reg[SQ_STEPS]);
            ym_reg <= AW'(yabs) << 8;
            xn_reg <= sqd_reg[SQ_STEPS][PW-1];
            yn_reg <= sqy_reg[SQ_STEPS][YW-1];
            zn_reg <= (sqn_reg[SQ_STEPS] == '0);
        end
    end

    // normalize stage: leading one of the larger magnitude to bit 29
    logic           vn_reg;
    logic signed [33:0] cx_reg [CORDIC_STEPS+1];
    logic signed [33:0] cy_reg [CORDIC_STEPS+1];
    logic signed [33:0] ca_reg [CORDIC_STEPS+1];
    logic           cv_reg [CORDIC_STEPS+1];
    logic           cz_reg [CORDIC_STEPS+1];
    logic           cd_reg [CORDIC_STEPS+1];
    logic [AW-1:0]  orm;
    logic [7:0]     lead;
    logic [AW-1:0]  xsh;
    logic [AW-1:0]  ysh;
    logic signed [33:0] xs0;
    logic signed [33:0] ys0;
    always_comb
    begin
        orm  = xm_reg | ym_reg;
        lead = '0;
        for (int i = 0; i < AW; i++)
            if (orm[i])
                lead = 8'(i);
        if (lead >= 8'd29)
        begin
            xsh = xm_reg >> (lead - 8'd29);
            ysh = ym_reg >> (lead - 8'd29);
        end
        else
        begin
            xsh = xm_reg << (8'd29 - lead);
            ysh = ym_reg << (8'd29 - lead);
        end
        xs0 = xn_reg ? -34'(xsh[30:0]) : 34'(xsh[30:0]);
        ys0 = yn_reg ? -34'(ysh[30:0]) : 34'(ysh[30:0]);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vn_reg <= 1'b0;
        else if (adv)
            vn_reg <= vx_reg;
    end
    assign cv_reg[0] = vn_reg;
    // quarter turn for negative x, then pipeline input
    logic signed [33:0] qx_reg;
    logic signed [33:0] qy_reg;
    logic signed [33:0] qa_reg;
    logic               qz_reg;
    logic               qd_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qz_reg <= zn_reg;
            qd_reg <= (orm == '0);
            if (xs0 < 0)
            begin
                if (ys0 >= 0)
                begin
                    qx_reg <= ys0;
                    qy_reg <= -xs0;
                    qa_reg <= 34'sd1 <<< 30;
                end
                else
                begin
                    qx_reg <= -ys0;
                    qy_reg <= xs0;
                    qa_reg <= -(34'sd1 <<< 30);
                end
            end
            else
            begin
                qx_reg <= xs0;
                qy_reg <= ys0;
                qa_reg <= '0;
            end
        end
    end
    always_comb
    begin
        cx_reg[0] = qx_reg;
        cy_reg[0] = qy_reg;
        ca_reg[0] = qa_reg;
        cz_reg[0] = qz_reg;
        cd_reg[0] = qd_reg;
    end

    // cordic vectoring stages
    for (genvar s = 0; s < CORDIC_STEPS; s++)
    begin : g_cordic
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        assign dx = cy_reg[s] >>> s;
        assign dy = cx_reg[s] >>> s;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[s+1] <= 1'b0;
            else if (adv)
                cv_reg[s+1] <= cv_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cz_reg[s+1] <= cz_reg[s];
                cd_reg[s+1] <= cd_reg[s];
                if (cy_reg[s] > 0)
                begin
                    cx_reg[s+1] <= cx_reg[s] + dx;
                    cy_reg[s+1] <= cy_reg[s] - dy;
                    ca_reg[s+1] <= ca_reg[s] + 34'(ATAN_TAB[s]);
                end
                else
                begin
                    cx_reg[s+1] <= cx_reg[s] - dx;
                    cy_reg[s+1] <= cy_reg[s] + dy;
                    ca_reg[s+1] <= ca_reg[s] - 34'(ATAN_TAB[s]);
                end
            end
        end
    end

    // output stage: rounding and special cases
    localparam int SH = 32 - ANGLE_WIDTH;
    logic signed [33:0] rnd;
    logic               ov_reg;
    logic signed [ANGLE_WIDTH-1:0] ang_reg;
    logic               az_reg;
    assign rnd = (ca_reg[CORDIC_STEPS] + (34'sd1 <<< (SH - 1))) >>> SH;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= cv_reg[CORDIC_STEPS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            az_reg  <= cz_reg[CORDIC_STEPS];
            ang_reg <= (cz_reg[CORDIC_STEPS] || cd_reg[CORDIC_STEPS])
                       ? '0 : ANGLE_WIDTH'(rnd);
        end
    end
    assign out_valid = ov_reg;
    assign angle     = ang_reg;
    assign axis_zero = az_reg;

    `SAN_ASSERT_IMP(a_ready_follows, clk, rst_n, out_valid && !out_ready, !in_ready)
    `SAN_ASSERT_NXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)
    `SAN_ASSERT_NXT(a_hold_angle, clk, rst_n, out_valid && !out_ready, $stable(angle))
    `SAN_ASSERT_IMP(a_zero_angle, clk, rst_n, out_valid && axis_zero, angle == '0)
endmodule
